[sv/bcld_pkg.sv]
package bcld_pkg;

  // field widths fixed by the item format
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LINE_W = 13;
  localparam int unsigned COL_W  = 13;
  localparam int unsigned KIND_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_READ,
    ST_DONE
  } state_e;

  // write-side request to the text store
  typedef struct packed {
    logic              clear;
    logic              append;
    logic [BYTE_W-1:0] data;
  } store_req_t;

endpackage

[sv/bcld_if.sv]
interface bcld_in_if;
  import bcld_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] text_byte;
  logic [LINE_W-1:0] line_number;
  logic [COL_W-1:0]  column;
  logic              last_pair;

  modport source (output valid, kind, text_byte, line_number, column, last_pair,
                  input ready);
  modport sink   (input valid, kind, text_byte, line_number, column, last_pair,
                  output ready);
endinterface

interface bcld_out_if;
  import bcld_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] character;
  logic              status;
  logic              last;

  modport source (output valid, character, status, last, input ready);
  modport sink   (input valid, character, status, last, output ready);
endinterface

[sv/bcld_store.sv]
module bcld_store
  import bcld_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = 4096,
  localparam int unsigned AW = $clog2(TEXT_DEPTH),
  localparam int unsigned LW = $clog2(TEXT_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  store_req_t        req_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [BYTE_W-1:0] rd_data_o,
  output logic [LW-1:0]     length_o
);

  logic [BYTE_W-1:0] mem_q [TEXT_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic [LW-1:0]     length_q;
  logic [LW-1:0]     length_d;
  logic              wr_en;

  // appends past capacity are dropped
  assign wr_en = req_i.append && (length_q < LW'(TEXT_DEPTH));

  // fill count
  always_comb begin
    length_d = length_q;
    if (req_i.clear) begin
      length_d = '0;
    end else if (wr_en) begin
      length_d = length_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
    end else begin
      length_q <= length_d;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[length_q[AW-1:0]] <= req_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign length_o  = length_q;

endmodule

[sv/book_cipher_line_column_decode.sv]
// channel | dir | modport        | payload
// --------+-----+----------------+------------------------------------------------
// in_i    | in  | bcld_in_if     | kind, text_byte, line_number, column, last_pair
// out_o   | out | bcld_out_if    | character, status, last
//
// After a clear or an append, in_i.ready stays high.
// A query walks the bytes before the wanted line starts (one a cycle), then passes
// FIN and READ to DONE; a missing line goes from WALK to DONE, a bad column from FIN.
// Reset empties the store (fill count only, no clearing pass) and the output.
// A result sits in the output register; new items are taken while it waits,
// but a finished query holds the sequencer until the output register is free.
module book_cipher_line_column_decode
  import bcld_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bcld_in_if.sink           in_i,
  bcld_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(TEXT_DEPTH);
  localparam int unsigned LW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned FW = ((LW > COL_W) ? LW : COL_W) + 1;

  state_e            state_q, state_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic [LINE_W-1:0] passed_q, passed_d;
  logic [LINE_W-1:0] need_q, need_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              last_q, last_d;
  logic [BYTE_W-1:0] res_char_q, res_char_d;
  logic              res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_char_q, out_char_d;
  logic              out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  store_req_t        store_req;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [LW-1:0]     text_len;

  logic              in_xfer;
  logic              walk_done;
  logic              walk_end;
  logic [FW-1:0]     fpos_addend;
  logic [FW-1:0]     fpos;
  logic              fin_bad;
  logic              out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // text store write requests
  always_comb begin
    store_req.clear  = in_xfer && (in_i.kind == KIND_CLEAR);
    store_req.append = in_xfer && (in_i.kind == KIND_APPEND);
    store_req.data   = in_i.text_byte;
  end

  bcld_store #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .length_o  (text_len)
  );

  // walk conditions, rd_data holds the byte at pos_q
  assign walk_done = (passed_q == need_q);
  assign walk_end  = (pos_q >= text_len);

  // final position: line start plus column minus one
  assign fpos_addend = (col_q == '0) ? {FW{1'b1}} : FW'(col_q - 1'b1);
  assign fpos        = FW'(pos_q) + fpos_addend;
  assign fin_bad     = ((col_q == '0) && (pos_q == '0)) || (fpos >= FW'(text_len));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.kind == KIND_QUERY)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_FIN;
        end else if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_FIN: begin
        state_d = fin_bad ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and result updates
  always_comb begin
    pos_d        = pos_q;
    passed_d     = passed_q;
    need_d       = need_q;
    col_d        = col_q;
    last_d       = last_q;
    res_char_d   = res_char_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_char_d   = out_char_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.kind == KIND_QUERY)) begin
          pos_d    = '0;
          passed_d = '0;
          need_d   = (in_i.line_number == '0) ? '0 : in_i.line_number - 1'b1;
          col_d    = in_i.column;
          last_d   = in_i.last_pair;
        end
      end
      ST_WALK: begin
        if (!walk_done) begin
          if (walk_end) begin
            res_char_d   = '0;
            res_status_d = STATUS_RANGE;
          end else begin
            pos_d = pos_q + 1'b1;
            if (rd_data == NEWLINE_BYTE) begin
              passed_d = passed_q + 1'b1;
            end
          end
        end
      end
      ST_FIN: begin
        if (fin_bad) begin
          res_char_d   = '0;
          res_status_d = STATUS_RANGE;
        end
      end
      ST_READ: begin
        res_char_d   = rd_data;
        res_status_d = STATUS_OK;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = res_char_q;
          out_status_d = res_status_q;
          out_last_d   = last_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_o.ready;
      end
    endcase
  end

  // store read address: next walk position, or the final position
  always_comb begin
    if (state_q == ST_FIN) begin
      rd_addr = fpos[AW-1:0];
    end else begin
      rd_addr = pos_d[AW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    passed_q     <= passed_d;
    need_q       <= need_d;
    col_q        <= col_d;
    last_q       <= last_d;
    res_char_q   <= res_char_d;
    res_status_q <= res_status_d;
    out_char_q   <= out_char_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

endmodule

[sv/bcld_checker.sv]
module bcld_checker
  import bcld_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KIND_W-1:0] in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] out_character_i,
  input logic              out_status_i,
  input logic              out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_character_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // out-of-range results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == STATUS_RANGE) |-> (out_character_i == '0))
    else $error("out-of-range result with nonzero character");

  // a query keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i == KIND_QUERY) |=> !in_ready_i)
    else $error("ready right after a query transfer");

  // clear, append and unused kinds leave the block ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_kind_i != KIND_QUERY) |=> in_ready_i)
    else $error("not ready after a store update");

endmodule

bind book_cipher_line_column_decode bcld_checker u_bcld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_kind_i       (in_i.kind),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_status_i    (out_o.status),
  .out_last_i      (out_o.last)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import bcld_pkg::*;

  localparam int unsigned TEXT_DEPTH  = 4096;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] text_byte;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
    logic              last_pair;
    bit                drain;
  } cipher_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] character;
    logic              status;
    logic              last;
  } decoded_char_t;

  logic clk_i;
  logic rst_ni;

  bcld_in_if  in_if ();
  bcld_out_if out_if ();

  book_cipher_line_column_decode #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor copy of the text page
  logic [BYTE_W-1:0] page_text [TEXT_DEPTH];
  int unsigned       page_len;

  cipher_item_t  cipher_items [$];
  decoded_char_t expected_chars [$];

  int unsigned error_count;
  int unsigned cycle_count;
  bit          in_xfer;
  bit          out_xfer;
  bit          pause_next;
  int          gap_left;
  int          gap_run;
  int          stall_left;
  int          stall_run;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // wait length for one item, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int run);
    int w;
    if (run > 0) begin
      run--;
      w = 0;
    end else begin
      w = $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) run = $urandom_range(8, 40);
    end
    return w;
  endfunction

  // predicted effect of one accepted item on the page and the result stream
  task automatic decode_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                             input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col,
                             input logic last_pair);
    int unsigned   need;
    int unsigned   pos;
    int unsigned   passed;
    bit            miss;
    decoded_char_t res;
    case (kind)
      KIND_CLEAR: begin
        page_len = 0;
      end
      KIND_APPEND: begin
        if (page_len < TEXT_DEPTH) begin
          page_text[page_len] = b;
          page_len++;
        end
      end
      KIND_QUERY: begin
        need   = (line == '0) ? 0 : int'(line) - 1;
        pos    = 0;
        passed = 0;
        miss   = 1'b0;
        // skip line-1 newlines from the start of the page
        while (passed < need && !miss) begin
          if (pos >= page_len) begin
            miss = 1'b1;
          end else begin
            if (page_text[pos] == NEWLINE_BYTE) passed++;
            pos++;
          end
        end
        if (!miss) begin
          if (col == '0) begin
            if (pos == 0) miss = 1'b1;
            else pos = pos - 1;
          end else begin
            pos = pos + int'(col) - 1;
          end
        end
        if (!miss && (pos >= page_len || pos >= TEXT_DEPTH)) miss = 1'b1;
        res.last = last_pair;
        if (miss) begin
          res.character = '0;
          res.status    = STATUS_RANGE;
        end else begin
          res.character = page_text[pos];
          res.status    = STATUS_OK;
        end
        expected_chars.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // transfers on both channels, sampled at the rising edge
  always @(posedge clk_i) begin
    decoded_char_t want;
    in_xfer  = rst_ni && in_if.valid && in_if.ready;
    out_xfer = rst_ni && out_if.valid && out_if.ready;
    if (in_xfer) begin
      decode_item(in_if.kind, in_if.text_byte, in_if.line_number, in_if.column,
                  in_if.last_pair);
    end
    if (out_xfer) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: character %02h status %0d last %0d",
                   out_if.character, out_if.status, out_if.last);
      end else begin
        want = expected_chars.pop_front();
        if (out_if.character !== want.character || out_if.status !== want.status ||
            out_if.last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected character %02h status %0d last %0d, got %02h %0d %0d",
                     want.character, want.status, want.last,
                     out_if.character, out_if.status, out_if.last);
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    cipher_item_t nxt;
    logic         drive_valid;
    if (rst_ni) begin
      drive_valid = in_if.valid;
      if (in_xfer) begin
        drive_valid = 1'b0;
        gap_left    = draw_wait(gap_run);
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cipher_items.size() != 0 &&
                     !(cipher_items[0].drain && expected_chars.size() != 0)) begin
          nxt = cipher_items.pop_front();
          in_if.kind        <= nxt.kind;
          in_if.text_byte   <= nxt.text_byte;
          in_if.line_number <= nxt.line_number;
          in_if.column      <= nxt.column;
          in_if.last_pair   <= nxt.last_pair;
          drive_valid = 1'b1;
        end
      end
      in_if.valid <= drive_valid;
    end
  end

  // result receiver with random back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) stall_left = draw_wait(stall_run);
      if (out_if.valid && stall_left > 0) stall_left--;
      out_if.ready <= (stall_left == 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                            input logic [LINE_W-1:0] line, input logic [COL_W-1:0] col,
                            input logic last_pair);
    cipher_item_t it;
    it.kind        = kind;
    it.text_byte   = b;
    it.line_number = line;
    it.column      = col;
    it.last_pair   = last_pair;
    it.drain       = pause_next;
    pause_next     = 1'b0;
    cipher_items.push_back(it);
  endtask

  // stimulus
  initial begin
    int unsigned       random_count;
    int unsigned       gen_lines;
    int unsigned       n;
    int unsigned       q;
    logic [BYTE_W-1:0] b;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;

    in_if.valid       = 1'b0;
    in_if.kind        = KIND_CLEAR;
    in_if.text_byte   = '0;
    in_if.line_number = '0;
    in_if.column      = '0;
    in_if.last_pair   = 1'b0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    page_len    = 0;
    error_count = 0;
    cycle_count = 0;
    in_xfer     = 1'b0;
    out_xfer    = 1'b0;
    pause_next  = 1'b0;
    gap_left    = 0;
    gap_run     = 0;
    stall_left  = 0;
    stall_run   = 0;

    // directed: empty page, ignored kind, short two-line text
    queue_item(KIND_QUERY, 8'h00, 13'd1, 13'd1, 1'b0);
    queue_item(KIND_QUERY, 8'h00, 13'd0, 13'd0, 1'b1);
    queue_item(KIND_UNUSED, 8'hFF, 13'h1FFF, 13'h1FFF, 1'b1);
    queue_item(KIND_APPEND, 8'h61, 13'h1FFF, 13'h1FFF, 1'b1);
    queue_item(KIND_APPEND, 8'h00, 13'd0, 13'd0, 1'b0);
    queue_item(KIND_APPEND, NEWLINE_BYTE, 13'd0, 13'd0, 1'b0);
    queue_item(KIND_APPEND, 8'hFF, 13'd0, 13'd0, 1'b0);
    queue_item(KIND_APPEND, 8'h64, 13'd0, 13'd0, 1'b0);
    queue_item(KIND_APPEND, NEWLINE_BYTE, 13'd0, 13'd0, 1'b0);
    queue_item(KIND_QUERY, 8'h00, 13'd0, 13'd1, 1'b0);      // line zero as line one
    queue_item(KIND_QUERY, 8'h00, 13'd1, 13'd0, 1'b1);      // column zero at page start
    queue_item(KIND_QUERY, 8'h00, 13'd2, 13'd0, 1'b0);      // column zero picks prior newline
    queue_item(KIND_QUERY, 8'h00, 13'd2, 13'd1, 1'b0);
    queue_item(KIND_QUERY, 8'h00, 13'd2, 13'd2, 1'b1);
    queue_item(KIND_QUERY, 8'h00, 13'd1, 13'd5, 1'b0);      // column runs past line end
    queue_item(KIND_QUERY, 8'h00, 13'd3, 13'd1, 1'b0);      // at loaded length
    queue_item(KIND_QUERY, 8'h00, 13'd3, 13'd0, 1'b1);
    queue_item(KIND_QUERY, 8'h00, 13'd4, 13'd1, 1'b0);      // missing line
    queue_item(KIND_QUERY, 8'hFF, 13'h1FFF, 13'h1FFF, 1'b1);
    queue_item(KIND_QUERY, 8'h00, 13'd0, 13'h1FFF, 1'b0);
    queue_item(KIND_CLEAR, 8'hFF, 13'h1FFF, 13'h1FFF, 1'b1);
    queue_item(KIND_QUERY, 8'h00, 13'd1, 13'd1, 1'b1);
    pause_next = 1'b1;
    queue_item(KIND_CLEAR, 8'h00, 13'd0, 13'd0, 1'b0);

    // random: short texts followed by line and column lookups
    random_count = 0;
    gen_lines    = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) pause_next = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        queue_item(KIND_CLEAR, BYTE_W'($urandom), LINE_W'($urandom), COL_W'($urandom),
                   1'($urandom));
        gen_lines = 0;
        random_count++;
      end
      n = $urandom_range(0, 40);
      for (int i = 0; i < n; i++) begin
        b = ($urandom_range(0, 4) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE) gen_lines++;
        queue_item(KIND_APPEND, b, LINE_W'($urandom), COL_W'($urandom), 1'($urandom));
        random_count++;
      end
      q = $urandom_range(1, 8);
      for (int i = 0; i < q; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          line = LINE_W'($urandom);
          col  = COL_W'($urandom);
        end else begin
          line = LINE_W'($urandom_range(0, gen_lines + 2));
          col  = COL_W'($urandom_range(0, 24));
        end
        queue_item(KIND_QUERY, BYTE_W'($urandom), line, col, 1'($urandom));
        random_count++;
        // noise: ignored items between lookups
        if ($urandom_range(0, 7) == 0)
          queue_item(KIND_UNUSED, BYTE_W'($urandom), LINE_W'($urandom), COL_W'($urandom),
                     1'($urandom));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain everything, then give stray results a chance to show up
    while (cipher_items.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("mismatches: %0d", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
